// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the sorted set port checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/ssi_pkg.sv -----
// ----------------------------------------------------------------------------
// ssi_pkg
// types and constants of the sorted set insert block
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DUMP   = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_ELEMENT   = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd                       command;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  element;
        logic [COUNT_W-1:0]         stored_count;
        logic                       last;
    } t_out_item;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                       insert;
        logic                       rotate;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

endpackage

// ----- rtl/core/ssi_cell.sv -----
// ----------------------------------------------------------------------------
// ssi_cell
// one slot of the sorted chain: compare, shift right on insert, rotate on dump
// ----------------------------------------------------------------------------
module ssi_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                                i_clk,
    input  ssi_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic                                i_left_bigger,
    input  logic signed [ssi_pkg::VALUE_W-1:0]  i_left_value,
    input  logic signed [ssi_pkg::VALUE_W-1:0]  i_right_value,
    input  logic signed [ssi_pkg::VALUE_W-1:0]  i_head_value,
    output logic signed [ssi_pkg::VALUE_W-1:0]  o_value,
    output logic                                o_bigger,
    output logic                                o_eq
);

    logic signed [ssi_pkg::VALUE_W-1:0] r_value;
    logic signed [ssi_pkg::VALUE_W-1:0] n_value;
    logic                               w_occupied;
    logic                               w_wrap;

    assign w_occupied = i_count > CNT_W'(IDX);
    assign w_wrap     = i_count == CNT_W'(IDX + 1);
    assign o_bigger   = !w_occupied || (r_value > i_ctrl.value);
    assign o_eq       = w_occupied && (r_value == i_ctrl.value);
    assign o_value    = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert && o_bigger) begin
            n_value = i_left_bigger ? i_left_value : i_ctrl.value;
        end else if (i_ctrl.rotate) begin
            n_value = w_wrap ? i_head_value : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- rtl/core/sorted_set_insert.sv -----
// insert: result in the cycle after the accepted transaction, next transaction any cycle
// dump of n held values: n results on consecutive cycles via the dump state and result
// register, busy in dump state (one cell rotation per element); empty dump: 1 result
// results cannot be stalled; a strobe marks each one for a single cycle
// synchronous active-low reset empties the set and returns to idle; cell data not reset
// ----------------------------------------------------------------------------
// sorted_set_insert
// bounded ascending set of signed values in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
module sorted_set_insert #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  ssi_pkg::t_in_item    i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output ssi_pkg::t_out_item   o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OW    = ssi_pkg::COUNT_W;
    localparam int VW    = ssi_pkg::VALUE_W;

    ssi_pkg::t_state      r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_strobe, n_strobe;
    ssi_pkg::t_out_item   r_result, n_result;
    ssi_pkg::t_cell_ctrl  w_ctrl;

    logic signed [VW-1:0] w_value  [CAPACITY];
    logic [CAPACITY-1:0]  w_bigger;
    logic [CAPACITY-1:0]  w_eq;
    logic                 w_accept;
    logic                 w_dup;
    logic                 w_full;
    logic                 w_last;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            ssi_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_count       (r_count),
                .i_left_bigger ((gi == 0) ? 1'b0 : w_bigger[(gi == 0) ? 0 : gi-1]),
                .i_left_value  (w_value[(gi == 0) ? 0 : gi-1]),
                .i_right_value (w_value[(gi == CAPACITY-1) ? gi : gi+1]),
                .i_head_value  (w_value[0]),
                .o_value       (w_value[gi]),
                .o_bigger      (w_bigger[gi]),
                .o_eq          (w_eq[gi])
            );
        end
    endgenerate

    assign busy     = (r_state == ssi_pkg::S_DUMP);
    assign w_accept = start && !busy;
    assign w_dup    = |w_eq;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_last   = (r_idx == r_count - CNT_W'(1));

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_idx           = r_idx;
        n_strobe        = 1'b0;
        n_result        = r_result;
        w_ctrl.insert   = 1'b0;
        w_ctrl.rotate   = 1'b0;
        w_ctrl.value    = i_item.value;
        unique case (r_state)
            ssi_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_item.command == ssi_pkg::CMD_INSERT) begin
                        n_strobe         = 1'b1;
                        n_result.element = '0;
                        n_result.last    = 1'b1;
                        if (w_dup) begin
                            n_result.status = ssi_pkg::ST_DUPLICATE;
                        end else if (w_full) begin
                            n_result.status = ssi_pkg::ST_FULL;
                        end else begin
                            n_result.status = ssi_pkg::ST_INSERTED;
                            w_ctrl.insert   = 1'b1;
                            n_count         = r_count + CNT_W'(1);
                        end
                        n_result.stored_count = OW'(n_count);
                    end else if (r_count == '0) begin
                        n_strobe              = 1'b1;
                        n_result.status       = ssi_pkg::ST_EMPTY;
                        n_result.element      = '0;
                        n_result.stored_count = '0;
                        n_result.last         = 1'b1;
                    end else begin
                        n_state = ssi_pkg::S_DUMP;
                        n_idx   = '0;
                    end
                end
            end
            ssi_pkg::S_DUMP: begin
                w_ctrl.rotate         = 1'b1;
                n_strobe              = 1'b1;
                n_result.status       = ssi_pkg::ST_ELEMENT;
                n_result.element      = w_value[0];
                n_result.stored_count = OW'(r_count);
                n_result.last         = w_last;
                n_idx                 = r_idx + CNT_W'(1);
                if (w_last) begin
                    n_state = ssi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ssi_pkg::S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/core/ssi_checker.sv -----
// ----------------------------------------------------------------------------
// ssi_port_checker
// port-level checks of the sorted set insert block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssi_port_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input ssi_pkg::t_in_item   i_item,
    input logic                busy,
    input logic                o_strobe,
    input ssi_pkg::t_out_item  o_result
);

    logic w_insert_acc;
    logic w_single_ans;
    logic w_elem;
    logic w_elem_more;

    assign w_insert_acc = start && !busy && i_item.command == ssi_pkg::CMD_INSERT;
    assign w_single_ans = o_strobe && o_result.last && !busy;
    assign w_elem       = o_strobe && o_result.status == ssi_pkg::ST_ELEMENT;
    assign w_elem_more  = w_elem && !o_result.last;

    // every insert transaction answers in the next cycle with a single result
    `CHK_NEXT(a_insert_answer, i_clk, i_rst_n, w_insert_acc, w_single_ans)

    // only dumped elements can be followed by more results of the same transaction
    `CHK_SAME(a_single_last, i_clk, i_rst_n, o_strobe && !w_elem, o_result.last)

    // a dump stream runs without gaps until its last element
    `CHK_NEXT(a_dump_stream, i_clk, i_rst_n, w_elem_more, w_elem)

    // a successful insert leaves a nonempty set
    `CHK_SAME(a_insert_count, i_clk, i_rst_n, o_strobe && o_result.status == ssi_pkg::ST_INSERTED, o_result.stored_count != '0)

endmodule

bind sorted_set_insert ssi_port_checker u_ssi_port_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- dv/ssi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_checker
// watches the command and result channels of the sorted set, keeps its own
// ordered copy of the held values, predicts every result and compares them
// ----------------------------------------------------------------------------
module ssi_checker
    import ssi_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  t_in_item   i_item,
    input  logic       o_strobe,
    input  t_out_item  o_result,
    output int         o_mismatches,
    output int         o_outstanding
);

    logic signed [VALUE_W-1:0] held_values[$];
    t_out_item                 awaited_results[$];
    int                        mismatch_count = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic predict_set_command(input t_in_item item);
        logic signed [VALUE_W-1:0] v;
        t_out_item                 r;
        int                        pos;
        v   = $signed(item.value);
        pos = 0;
        r   = '0;
        if (item.command == CMD_INSERT) begin
            while (pos < held_values.size() && held_values[pos] < v) pos++;
            if (pos < held_values.size() && held_values[pos] == v) begin
                r.status = ST_DUPLICATE;
            end else if (held_values.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                held_values.insert(pos, v);
                r.status = ST_INSERTED;
            end
            r.stored_count = COUNT_W'(held_values.size());
            r.last         = 1'b1;
            awaited_results.push_back(r);
        end else if (held_values.size() == 0) begin
            r.status = ST_EMPTY;
            r.last   = 1'b1;
            awaited_results.push_back(r);
        end else begin
            foreach (held_values[i]) begin
                r.status       = ST_ELEMENT;
                r.element      = held_values[i];
                r.stored_count = COUNT_W'(held_values.size());
                r.last         = (i == held_values.size() - 1);
                awaited_results.push_back(r);
            end
        end
    endtask

    task automatic compare_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%t unexpected result: status %0d element %0d count %0d last %0d",
                         $realtime, got.status, $signed(got.element), got.stored_count,
                         got.last);
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.stored_count !== want.stored_count || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%t mismatch: expected status %0d element %0d count %0d last %0d, %s",
                         $realtime, want.status, $signed(want.element), want.stored_count,
                         want.last,
                         $sformatf("got status %0d element %0d count %0d last %0d",
                                   got.status, $signed(got.element), got.stored_count,
                                   got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                compare_result(o_result);
            if (start && !busy)
                predict_set_command(i_item);
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= awaited_results.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives insert and dump transactions into the sorted set with random gaps until CALM_FROM;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import ssi_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_FROM    = 400;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    int        mismatches;
    int        outstanding;
    int        issued = 0;
    logic signed [VALUE_W-1:0] sent_values[$];

    sorted_set_insert #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    ssi_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_strobe      (o_strobe),
        .o_result      (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

    task automatic send_transaction(input t_cmd cmd, input logic signed [VALUE_W-1:0] v);
        int gap;
        t_in_item item;
        if (issued < CALM_FROM && $urandom_range(3) == 0) begin
            gap = $urandom_range(14, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.command = cmd;
        item.value   = v;
        i_item <= item;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        issued++;
        if (cmd == CMD_INSERT)
            sent_values.push_back(v);
    endtask

    function automatic logic signed [VALUE_W-1:0] fresh_value();
        case ($urandom_range(5))
            0:       return 32'sh7fffffff - $urandom_range(3);
            1:       return 32'sh80000000 + $urandom_range(3);
            2:       return $signed($urandom_range(40)) - 20;
            default: return $signed($urandom);
        endcase
    endfunction

    initial begin
        int kind;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, extremes, duplicates of head and tail
        send_transaction(CMD_DUMP, $signed($urandom));
        send_transaction(CMD_INSERT, 32'sd0);
        send_transaction(CMD_INSERT, 32'sd0);
        send_transaction(CMD_INSERT, 32'sh7fffffff);
        send_transaction(CMD_INSERT, 32'sh80000000);
        send_transaction(CMD_INSERT, 32'sh80000000);
        send_transaction(CMD_INSERT, -32'sd1);
        send_transaction(CMD_INSERT, 32'sd1);
        send_transaction(CMD_INSERT, 32'sh7fffffff);
        send_transaction(CMD_DUMP, $signed($urandom));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(99);
            if (kind < 10)
                send_transaction(CMD_DUMP, $signed($urandom));
            else if (kind < 45)
                send_transaction(CMD_INSERT,
                                 sent_values[$urandom_range(sent_values.size() - 1)]);
            else
                send_transaction(CMD_INSERT, fresh_value());
        end
        start <= 1'b0;

        for (int w = 0; w < 2000 && outstanding != 0; w++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
